@@ rtl/core/itoa_pkg.sv @@
package itoa_pkg;

   localparam int unsigned MAX_WIDTH_DEF = 32;
   localparam int unsigned RESULT_LIMIT  = 34;
   localparam int unsigned NUM_DIGITS    = 22;
   localparam int unsigned DIGIT_BITS    = 4 * NUM_DIGITS;
   localparam int unsigned TEXT_CHARS    = 20;
   localparam int unsigned TEXT_BITS     = 8 * TEXT_CHARS;
   localparam int unsigned QUEUE_DEPTH   = 2;

   // operand size codes
   localparam logic [1:0] SIZE_8  = 2'd0;
   localparam logic [1:0] SIZE_16 = 2'd1;
   localparam logic [1:0] SIZE_32 = 2'd2;
   localparam logic [1:0] SIZE_64 = 2'd3;

   // radix_select codes; anything else is hex
   localparam logic [1:0] RSEL_OCT = 2'd0;
   localparam logic [1:0] RSEL_DEC = 2'd1;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_UPPER = 8'h41;
   localparam logic [7:0] CHAR_LOWER = 8'h61;

   typedef enum logic [1:0] {
      RADIX_OCT,
      RADIX_DEC,
      RADIX_HEX
   } radix_type;

   typedef enum logic [3:0] {
      HEAD_NONE,
      HEAD_MINUS,
      HEAD_PREFIX,
      HEAD_ZERO,
      HEAD_NIL,
      HEAD_MIN8,
      HEAD_MIN16,
      HEAD_MIN32,
      HEAD_MIN64
   } head_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_CONV,
      BACK_HEAD,
      BACK_WALK
   } back_state_type;

   typedef struct packed {
      head_type    head;
      logic [1:0]  size;
      radix_type   radix;
      logic        upper;
      logic        wgiven;
      logic        pad;
      logic [5:0]  width;
      logic        has_digits;
      logic [63:0] mag;
   } entry_type;

   localparam logic [TEXT_BITS-1:0] TXT_MINUS  = {"-", (TEXT_BITS - 8)'(0)};
   localparam logic [TEXT_BITS-1:0] TXT_PREFIX = {"0x", (TEXT_BITS - 16)'(0)};
   localparam logic [TEXT_BITS-1:0] TXT_ZERO   = {"0", (TEXT_BITS - 8)'(0)};
   localparam logic [TEXT_BITS-1:0] TXT_NIL    = {"(nil)", (TEXT_BITS - 40)'(0)};
   localparam logic [TEXT_BITS-1:0] TXT_MIN8   = {"-128", (TEXT_BITS - 32)'(0)};
   localparam logic [TEXT_BITS-1:0] TXT_MIN16  = {"-32768", (TEXT_BITS - 48)'(0)};
   localparam logic [TEXT_BITS-1:0] TXT_MIN32  = {"-2147483648", (TEXT_BITS - 88)'(0)};
   localparam logic [TEXT_BITS-1:0] TXT_MIN64  = "-9223372036854775808";

   function automatic logic [4:0] head_len(input head_type head);
      logic [4:0] len;
      unique case (head)
         HEAD_MINUS:  len = 5'd1;
         HEAD_PREFIX: len = 5'd2;
         HEAD_ZERO:   len = 5'd1;
         HEAD_NIL:    len = 5'd5;
         HEAD_MIN8:   len = 5'd4;
         HEAD_MIN16:  len = 5'd6;
         HEAD_MIN32:  len = 5'd11;
         HEAD_MIN64:  len = 5'd20;
         default:     len = 5'd0;
      endcase
      return len;
   endfunction

   function automatic logic [7:0] head_char(input head_type head, input logic [4:0] idx);
      logic [TEXT_BITS-1:0] txt;
      logic [TEXT_BITS-1:0] sh;
      unique case (head)
         HEAD_MINUS:  txt = TXT_MINUS;
         HEAD_PREFIX: txt = TXT_PREFIX;
         HEAD_ZERO:   txt = TXT_ZERO;
         HEAD_NIL:    txt = TXT_NIL;
         HEAD_MIN8:   txt = TXT_MIN8;
         HEAD_MIN16:  txt = TXT_MIN16;
         HEAD_MIN32:  txt = TXT_MIN32;
         HEAD_MIN64:  txt = TXT_MIN64;
         default:     txt = '0;
      endcase
      sh = txt << {idx, 3'b000};
      return sh[TEXT_BITS-1 -: 8];
   endfunction

   // digit positions a magnitude of this size can fill in this radix
   function automatic logic [4:0] max_digits(input logic [1:0] size, input radix_type radix);
      logic [4:0] n;
      unique case (radix)
         RADIX_OCT: begin
            unique case (size)
               SIZE_8:  n = 5'd3;
               SIZE_16: n = 5'd6;
               SIZE_32: n = 5'd11;
               default: n = 5'd22;
            endcase
         end
         RADIX_DEC: begin
            unique case (size)
               SIZE_8:  n = 5'd3;
               SIZE_16: n = 5'd5;
               SIZE_32: n = 5'd10;
               default: n = 5'd20;
            endcase
         end
         default: begin
            unique case (size)
               SIZE_8:  n = 5'd2;
               SIZE_16: n = 5'd4;
               SIZE_32: n = 5'd8;
               default: n = 5'd16;
            endcase
         end
      endcase
      return n;
   endfunction

   function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
      logic [7:0] ch;
      if (d < 4'd10) begin
         ch = CHAR_ZERO + {4'b0000, d};
      end else begin
         ch = (upper ? CHAR_UPPER : CHAR_LOWER) + {4'b0000, d - 4'd10};
      end
      return ch;
   endfunction

   // one shift-add-3 step of binary to BCD
   function automatic logic [DIGIT_BITS-1:0] dd_step(input logic [DIGIT_BITS-1:0] dig,
                                                     input logic b);
      logic [DIGIT_BITS-1:0] adj;
      adj = dig;
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (dig[4*i +: 4] >= 4'd5) begin
            adj[4*i +: 4] = dig[4*i +: 4] + 4'd3;
         end
      end
      return {adj[DIGIT_BITS-2:0], b};
   endfunction

   // octal and hex digits are plain bit fields of the magnitude
   function automatic logic [DIGIT_BITS-1:0] slice_digits(input logic [63:0] mag,
                                                          input radix_type radix);
      logic [DIGIT_BITS-1:0]   dig;
      logic [3*NUM_DIGITS-1:0] ext;
      ext = (3 * NUM_DIGITS)'(mag);
      if (radix == RADIX_OCT) begin
         for (int i = 0; i < NUM_DIGITS; i++) begin
            dig[4*i +: 4] = {1'b0, ext[3*i +: 3]};
         end
      end else begin
         dig = DIGIT_BITS'(mag);
      end
      return dig;
   endfunction

endpackage

@@ rtl/core/itoa_if.sv @@
interface itoa_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] value;
   logic [1:0]  value_size;
   logic        is_signed;
   logic [1:0]  radix_select;
   logic        upper_case;
   logic        hex_prefix;
   logic        zero_pad;
   logic        width_given;
   logic [5:0]  field_width;

   modport source (
      output valid, value, value_size, is_signed, radix_select, upper_case,
             hex_prefix, zero_pad, width_given, field_width,
      input  ready
   );
   modport sink (
      input  valid, value, value_size, is_signed, radix_select, upper_case,
             hex_prefix, zero_pad, width_given, field_width,
      output ready
   );
endinterface

interface itoa_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       last;

   modport source (output valid, out_char, last, input ready);
   modport sink (input valid, out_char, last, output ready);
endinterface

@@ rtl/core/itoa_front.sv @@
module itoa_front #(
   parameter int unsigned MAX_WIDTH = itoa_pkg::MAX_WIDTH_DEF
) (
   itoa_req_if.sink            req_bus,
   input  logic                q_full,
   output logic                push,
   output itoa_pkg::entry_type ent
);
   import itoa_pkg::*;

   localparam logic [5:0] WidthCap = 6'(MAX_WIDTH);
   localparam logic [5:0] LimitCap = 6'(RESULT_LIMIT);

   logic [63:0] mask;
   logic [63:0] signbit;
   logic [63:0] v;
   logic [63:0] mag;
   logic        is_zero;
   logic        neg;
   logic        is_min;
   logic        numeric;
   logic        has_digits;
   head_type    min_head;
   head_type    head;
   radix_type   radix;
   logic [1:0]  lead;
   logic [5:0]  limit;
   logic [5:0]  w;

   assign req_bus.ready = !q_full;

   always_comb begin
      unique case (req_bus.value_size)
         SIZE_8: begin
            mask     = 64'h0000_0000_0000_00FF;
            signbit  = 64'h0000_0000_0000_0080;
            min_head = HEAD_MIN8;
         end
         SIZE_16: begin
            mask     = 64'h0000_0000_0000_FFFF;
            signbit  = 64'h0000_0000_0000_8000;
            min_head = HEAD_MIN16;
         end
         SIZE_32: begin
            mask     = 64'h0000_0000_FFFF_FFFF;
            signbit  = 64'h0000_0000_8000_0000;
            min_head = HEAD_MIN32;
         end
         SIZE_64: begin
            mask     = 64'hFFFF_FFFF_FFFF_FFFF;
            signbit  = 64'h8000_0000_0000_0000;
            min_head = HEAD_MIN64;
         end
      endcase

      unique case (req_bus.radix_select)
         RSEL_OCT: radix = RADIX_OCT;
         RSEL_DEC: radix = RADIX_DEC;
         default:  radix = RADIX_HEX;
      endcase

      v       = req_bus.value & mask;
      is_zero = (v == 64'd0);
      neg     = req_bus.is_signed && ((v & signbit) != 64'd0);
      is_min  = neg && (v == signbit);
      mag     = neg ? ((~v + 64'd1) & mask) : v;
      numeric = !is_zero && !is_min;

      priority if (is_zero) begin
         head = req_bus.hex_prefix ? HEAD_NIL : HEAD_ZERO;
      end else if (is_min) begin
         head = min_head;
      end else if (neg) begin
         head = HEAD_MINUS;
      end else if (req_bus.hex_prefix && radix == RADIX_HEX) begin
         head = HEAD_PREFIX;
      end else begin
         head = HEAD_NONE;
      end

      // sign or prefix eats into the character budget
      unique case (head)
         HEAD_MINUS:  lead = 2'd1;
         HEAD_PREFIX: lead = 2'd2;
         default:     lead = 2'd0;
      endcase
      limit = LimitCap - {4'b0000, lead};
      w     = req_bus.field_width;
      if (w > WidthCap) begin
         w = WidthCap;
      end
      if (w > limit) begin
         w = limit;
      end

      has_digits = numeric && !(req_bus.width_given && w == 6'd0);

      // drop items that produce no characters at all
      push = req_bus.valid && req_bus.ready && (head != HEAD_NONE || has_digits);

      ent.head       = head;
      ent.size       = req_bus.value_size;
      ent.radix      = radix;
      ent.upper      = req_bus.upper_case;
      ent.wgiven     = req_bus.width_given;
      ent.pad        = req_bus.width_given && req_bus.zero_pad;
      ent.width      = w;
      ent.has_digits = has_digits;
      ent.mag        = mag;
   end

endmodule

@@ rtl/core/itoa_queue.sv @@
module itoa_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  itoa_pkg::entry_type push_ent,
   output logic                full,
   output logic                q_valid,
   output itoa_pkg::entry_type q_ent,
   input  logic                pop
);
   import itoa_pkg::*;

   localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LastPtr = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FullCnt = CNT_W'(QUEUE_DEPTH);

   entry_type        slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wptr_ff, wptr_in;
   logic [PTR_W-1:0] rptr_ff, rptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full    = (count_ff == FullCnt);
   assign q_valid = (count_ff != '0);
   assign q_ent   = slot_ff[rptr_ff];

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      if (push) begin
         wptr_in = (wptr_ff == LastPtr) ? '0 : wptr_ff + 1'b1;
      end
      if (pop) begin
         rptr_in = (rptr_ff == LastPtr) ? '0 : rptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wptr_ff] <= push_ent;
      end
   end

endmodule

@@ rtl/core/itoa_back.sv @@
module itoa_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  itoa_pkg::entry_type q_ent,
   output logic                pop,
   itoa_rsp_if.source          rsp_bus
);
   import itoa_pkg::*;

   back_state_type        st_ff, st_in;
   entry_type             ent_ff, ent_in;
   logic [DIGIT_BITS-1:0] dig_ff, dig_in;
   logic [63:0]           sh_ff, sh_in;
   logic [3:0]            cnt_ff, cnt_in;
   logic [4:0]            hidx_ff, hidx_in;
   logic [5:0]            widx_ff, widx_in;
   logic                  seen_ff, seen_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [7:0]            char_ff, char_in;
   logic                  last_ff, last_in;

   logic                  out_free;
   logic                  load_fixed;
   logic                  hlast;
   logic [DIGIT_BITS-1:0] dig_sh;
   logic [3:0]            wdig;
   logic                  nz;
   logic                  wemit;
   logic                  wstep;
   logic [DIGIT_BITS-1:0] dd;
   logic [4:0]            maxd;
   logic [5:0]            top;
   logic [63:0]           aligned;

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.out_char = char_ff;
   assign rsp_bus.last     = last_ff;

   assign out_free   = !rsp_valid_ff || rsp_bus.ready;
   assign load_fixed = (q_ent.head == HEAD_ZERO) || (q_ent.head == HEAD_NIL) ||
                       (q_ent.head == HEAD_MIN8) || (q_ent.head == HEAD_MIN16) ||
                       (q_ent.head == HEAD_MIN32) || (q_ent.head == HEAD_MIN64);
   assign hlast      = (hidx_ff == head_len(ent_ff.head) - 5'd1);

   // digit at the walk position; positions past the stored digits read zero
   assign dig_sh = dig_ff >> {widx_ff, 2'b00};
   assign wdig   = dig_sh[3:0];
   assign nz     = seen_ff || (wdig != 4'd0);
   assign wemit  = (!ent_ff.wgiven || widx_ff < ent_ff.width) && (ent_ff.pad || nz);
   assign wstep  = !wemit || out_free;

   always_comb begin
      dd = dig_ff;
      for (int k = 0; k < 4; k++) begin
         dd = dd_step(dd, sh_ff[63-k]);
      end
   end

   always_comb begin
      maxd = max_digits(q_ent.size, q_ent.radix);
      if (q_ent.pad && q_ent.width > {1'b0, maxd}) begin
         top = q_ent.width - 6'd1;
      end else begin
         top = {1'b0, maxd} - 6'd1;
      end
      unique case (q_ent.size)
         SIZE_8:  aligned = {q_ent.mag[7:0], 56'd0};
         SIZE_16: aligned = {q_ent.mag[15:0], 48'd0};
         SIZE_32: aligned = {q_ent.mag[31:0], 32'd0};
         SIZE_64: aligned = q_ent.mag;
      endcase
   end

   // next state
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         BACK_IDLE: begin
            if (q_valid) begin
               priority if (load_fixed) begin
                  st_in = BACK_HEAD;
               end else if (q_ent.has_digits && q_ent.radix == RADIX_DEC) begin
                  st_in = BACK_CONV;
               end else if (q_ent.head != HEAD_NONE) begin
                  st_in = BACK_HEAD;
               end else begin
                  st_in = BACK_WALK;
               end
            end
         end
         BACK_CONV: begin
            if (cnt_ff == 4'd0) begin
               st_in = (ent_ff.head != HEAD_NONE) ? BACK_HEAD : BACK_WALK;
            end
         end
         BACK_HEAD: begin
            if (out_free && hlast) begin
               st_in = ent_ff.has_digits ? BACK_WALK : BACK_IDLE;
            end
         end
         BACK_WALK: begin
            if (wstep && widx_ff == 6'd0) begin
               st_in = BACK_IDLE;
            end
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      pop          = 1'b0;
      ent_in       = ent_ff;
      dig_in       = dig_ff;
      sh_in        = sh_ff;
      cnt_in       = cnt_ff;
      hidx_in      = hidx_ff;
      widx_in      = widx_ff;
      seen_in      = seen_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      char_in      = char_ff;
      last_in      = last_ff;
      unique case (st_ff)
         BACK_IDLE: begin
            if (q_valid) begin
               pop     = 1'b1;
               ent_in  = q_ent;
               dig_in  = (q_ent.radix == RADIX_DEC) ? '0 : slice_digits(q_ent.mag, q_ent.radix);
               sh_in   = aligned;
               cnt_in  = 4'((2 << q_ent.size) - 1);
               hidx_in = 5'd0;
               widx_in = top;
               seen_in = 1'b0;
            end
         end
         BACK_CONV: begin
            // four magnitude bits per cycle into the BCD digits
            dig_in = dd;
            sh_in  = sh_ff << 4;
            cnt_in = cnt_ff - 4'd1;
         end
         BACK_HEAD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               char_in      = head_char(ent_ff.head, hidx_ff);
               last_in      = hlast && !ent_ff.has_digits;
               hidx_in      = hidx_ff + 5'd1;
            end
         end
         BACK_WALK: begin
            if (wemit && out_free) begin
               rsp_valid_in = 1'b1;
               char_in      = digit_char(wdig, ent_ff.upper);
               last_in      = (widx_ff == 6'd0);
            end
            if (wstep) begin
               seen_in = nz;
               widx_in = widx_ff - 6'd1;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= BACK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff  <= ent_in;
      dig_ff  <= dig_in;
      sh_ff   <= sh_in;
      cnt_ff  <= cnt_in;
      hidx_ff <= hidx_in;
      widx_ff <= widx_in;
      seen_ff <= seen_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

endmodule

@@ rtl/core/integer_to_ascii_formatter_top.sv @@
// Formats one integer (8/16/32/64-bit, signed or unsigned) as octal, decimal or hex ASCII,
// one character per rsp transfer with last set on the final one. The front classifies an
// item in the cycle it is accepted and parks it in a two-entry queue, so req keeps
// flowing while the queue has room and the back end works on earlier items. Per item the
// back end has a load step; for decimal, the 4-bit-per-cycle binary-to-BCD unit for
// 8/16/32/64-bit operands; a step per sign, prefix or fixed-text character; and a walk
// over the digit positions from the top position (all digit positions of the size
// and radix, or the field width when zero padding is wider) down to the last digit.
// Zero prints "0" (or "(nil)" with hex_prefix), the most negative value of each size
// prints its fixed decimal text, and an item that yields no characters produces no
// transfer at all.
module integer_to_ascii_formatter_top #(
   parameter int unsigned MAX_WIDTH = itoa_pkg::MAX_WIDTH_DEF
) (
   input logic        clock,
   input logic        reset,
   itoa_req_if.sink   req_bus,
   itoa_rsp_if.source rsp_bus
);
   import itoa_pkg::*;

   logic      push;
   entry_type push_ent;
   logic      q_full;
   logic      q_valid;
   entry_type q_ent;
   logic      pop;

   itoa_front #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .req_bus (req_bus),
      .q_full  (q_full),
      .push    (push),
      .ent     (push_ent)
   );

   itoa_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_ent (push_ent),
      .full     (q_full),
      .q_valid  (q_valid),
      .q_ent    (q_ent),
      .pop      (pop)
   );

   itoa_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_ent   (q_ent),
      .pop     (pop),
      .rsp_bus (rsp_bus)
   );

endmodule

@@ rtl/core/itoa_checker.sv @@
module itoa_checker (
   input logic        clock,
   input logic        reset,
   itoa_rsp_if.source rsp_bus
);
   import itoa_pkg::*;

   localparam logic [7:0] CharClose = 8'h29;
   localparam logic [5:0] LimitCnt  = 6'(RESULT_LIMIT);

   logic       xfer;
   logic [5:0] cnt_ff, cnt_in;

   assign xfer = rsp_bus.valid && rsp_bus.ready;

   // characters already sent for the current item
   always_comb begin
      cnt_in = cnt_ff;
      if (xfer) begin
         cnt_in = rsp_bus.last ? 6'd0 : cnt_ff + 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 6'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.ready |=>
         rsp_bus.valid && $stable(rsp_bus.out_char) && $stable(rsp_bus.last))
      else $error("rsp payload changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_bus.valid)
      else $error("rsp valid right after reset");

   a_item_len: assert property (@(posedge clock) disable iff (reset)
      xfer |-> cnt_ff < LimitCnt)
      else $error("too many characters for one item");

   a_nil_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.out_char == CharClose |-> rsp_bus.last)
      else $error("closing paren not flagged last");

endmodule

bind integer_to_ascii_formatter_top itoa_checker u_itoa_checker (
   .clock   (clock),
   .reset   (reset),
   .rsp_bus (rsp_bus)
);
